@@ src/assert_macros.svh @@
// assertion macros for the rtl files, included by rskf_ctrl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked assertion, disabled while reset is high
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// a condition that must never hold outside reset
`define ASSERT_NEVER(label, clk, rst, cond) \
  label: assert property (@(posedge clk) disable iff (rst) !(cond)) \
    else $error("forbidden condition");

`endif

@@ src/rskf_pkg.sv @@
// shared types and constants for the rssi kalman filter
`default_nettype none
package rskf_pkg;

  localparam int unsigned DIV_STEPS = 17;
  localparam int unsigned CNT_W     = $clog2(DIV_STEPS);
  localparam logic [16:0] ONE_Q16   = 17'h10000;

  localparam logic [1:0] REG_Q    = 2'd0;
  localparam logic [1:0] REG_R    = 2'd1;
  localparam logic [1:0] REG_INIT = 2'd2;

  localparam logic [31:0] RST_Q    = 32'd655;
  localparam logic [31:0] RST_R    = 32'd65536;
  localparam logic [31:0] RST_INIT = 32'd65536;

  typedef enum logic [2:0] {
    S_IDLE,
    S_PRIOR,
    S_SETUP,
    S_DIVIDE,
    S_MULT,
    S_UPDATE
  } state_t;

  typedef struct packed {
    logic load;
    logic prior_en;
    logic setup_en;
    logic div_step;
    logic mult_en;
    logic update_en;
  } cmd_t;

endpackage
`default_nettype wire

@@ src/rskf_ctrl.sv @@
// sequencer for one filter step and the result handshake
`default_nettype none
`include "assert_macros.svh"
module rskf_ctrl
  import rskf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic in_valid,
  output logic      in_ready,
  output logic      out_valid,
  input  wire logic out_ready,
  output cmd_t      cmd
);

  state_t state, state_next;
  logic [CNT_W-1:0] count;
  logic             last_step;

  assign last_step = (count == CNT_W'(DIV_STEPS - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.setup_en) begin
        count <= '0;
      end else if (cmd.div_step) begin
        count <= count + CNT_W'(1);
      end
      if (cmd.update_en) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (in_valid) state_next = S_PRIOR;
      S_PRIOR:  state_next = S_SETUP;
      S_SETUP:  state_next = S_DIVIDE;
      S_DIVIDE: if (last_step) state_next = S_MULT;
      S_MULT:   state_next = S_UPDATE;
      S_UPDATE: if (!out_valid || out_ready) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  always_comb begin
    in_ready      = (state == S_IDLE);
    cmd           = '0;
    cmd.load      = in_valid && (state == S_IDLE);
    cmd.prior_en  = (state == S_PRIOR);
    cmd.setup_en  = (state == S_SETUP);
    cmd.div_step  = (state == S_DIVIDE);
    cmd.mult_en   = (state == S_MULT);
    cmd.update_en = (state == S_UPDATE) && (!out_valid || out_ready);
  end

  `ASSERT_CLK(a_accept_starts, clk, rst, (in_valid && in_ready) |=> (state == S_PRIOR))
  `ASSERT_NEVER(a_count_range, clk, rst, (state == S_DIVIDE) && (count > CNT_W'(DIV_STEPS - 1)))
  `ASSERT_CLK(a_no_overwrite, clk, rst, (out_valid && !out_ready) |=> (out_valid && !$past(cmd.update_en)))

endmodule
`default_nettype wire

@@ src/rskf_datapath.sv @@
// filter state, settings, serial gain divider and update multipliers
`default_nettype none
module rskf_datapath
  import rskf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  input  wire logic [7:0]  rssi_dbm,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data,
  output logic [15:0]      smoothed_rssi,
  output logic [31:0]      error_variance
);

  logic [31:0] q_reg, r_reg, init_reg;
  logic        seeded;
  logic [15:0] estimate;
  logic [31:0] variance;
  logic [7:0]  sample;
  logic [31:0] prior;
  logic [32:0] den;
  logic [32:0] rem;
  logic [16:0] shift_bits;
  logic [16:0] quo;
  logic [48:0] prod_var;
  logic signed [34:0] prod_est;

  logic [32:0] prior_sum;
  logic [33:0] trial;
  logic [16:0] gain;
  logic signed [16:0] innov;
  logic [15:0] meas;

  assign prior_sum = {1'b0, variance} + {1'b0, q_reg};
  assign trial     = {rem, shift_bits[16]};
  assign gain      = (den == '0) ? '0 : quo;
  assign meas      = {sample, 8'h00};
  assign innov     = $signed({meas[15], meas}) - $signed({estimate[15], estimate});

  always_ff @(posedge clk) begin
    if (rst) begin
      q_reg    <= RST_Q;
      r_reg    <= RST_R;
      init_reg <= RST_INIT;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_Q:    q_reg    <= cfg_data;
        REG_R:    r_reg    <= cfg_data;
        REG_INIT: init_reg <= cfg_data;
        default:  ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seeded   <= 1'b0;
      estimate <= '0;
      variance <= '0;
    end else if (cmd.load) begin
      if (!seeded) begin
        seeded   <= 1'b1;
        estimate <= {rssi_dbm, 8'h00};
        variance <= init_reg;
      end
    end else if (cmd.update_en) begin
      estimate <= estimate + prod_est[31:16];
      variance <= prod_var[47:16];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      sample <= rssi_dbm;
    end
    if (cmd.prior_en) begin
      prior <= prior_sum[32] ? 32'hFFFF_FFFF : prior_sum[31:0];
    end
    if (cmd.setup_en) begin
      den        <= {1'b0, prior} + {1'b0, r_reg};
      rem        <= {2'b00, prior[31:1]};
      shift_bits <= {prior[0], 16'h0000};
      quo        <= '0;
    end else if (cmd.div_step) begin
      shift_bits <= {shift_bits[15:0], 1'b0};
      if (trial >= {1'b0, den}) begin
        rem <= 33'(trial - {1'b0, den});
        quo <= {quo[15:0], 1'b1};
      end else begin
        rem <= trial[32:0];
        quo <= {quo[15:0], 1'b0};
      end
    end
    if (cmd.mult_en) begin
      prod_var <= (ONE_Q16 - gain) * prior;
      prod_est <= $signed({1'b0, gain}) * innov;
    end
  end

  assign smoothed_rssi  = estimate;
  assign error_variance = variance;

endmodule
`default_nettype wire

@@ src/rssi_scalar_kalman_filter.sv @@
// top level of the rssi scalar kalman filter
//
// channel   direction  payload                          ready
// in        request    rssi_dbm                         low while a step runs
// out       result     smoothed_rssi, error_variance    from the consumer
// cfg       write      cfg_index, cfg_data              always high
//
// a result is produced for every request taken; no new request is taken while a step runs
// the gain comes from a 17-step restoring divider
// the next request is taken the cycle after the result is loaded
// a held result stalls the final update until the consumer takes it
// reset is synchronous, leaves the filter unseeded and restores the settings
`default_nettype none
module rssi_scalar_kalman_filter
  import rskf_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  rssi_dbm,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [15:0]      smoothed_rssi,
  output logic [31:0]      error_variance,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [31:0] cfg_data
);

  cmd_t cmd;

  assign cfg_ready = 1'b1;

  rskf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd)
  );

  rskf_datapath u_datapath (
    .clk            (clk),
    .rst            (rst),
    .cmd            (cmd),
    .rssi_dbm       (rssi_dbm),
    .cfg_we         (cfg_valid && cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .smoothed_rssi  (smoothed_rssi),
    .error_variance (error_variance)
  );

endmodule
`default_nettype wire

@@ dv/tb_top.sv @@
// self-checking testbench for the rssi scalar kalman filter
`default_nettype none
module tb_top
  import rskf_pkg::*;
();

  localparam logic [1:0] REG_NONE = 2'd3;
  localparam int unsigned LIMIT_CYCLES = 600000;
  localparam int unsigned LONG_HOLD = 400;
  localparam int unsigned DRAIN_CYCLES = 30;
  localparam int unsigned SEGMENTS = 5;
  localparam int unsigned SEG_ITEMS = 102;

  typedef enum logic {ROW_ITEM, ROW_CFG} row_kind_t;

  typedef struct packed {
    logic [15:0] est_q88;
    logic [31:0] var_q16;
  } kf_result_t;

  typedef struct packed {
    row_kind_t   kind;
    logic [1:0]  idx;
    logic [31:0] data;
    logic [7:0]  rssi;
    logic        typed;
    logic [15:0] t_est;
    logic [31:0] t_var;
  } plan_row_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  rssi_dbm = 8'd0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] smoothed_rssi;
  logic [31:0] error_variance;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = 2'd0;
  logic [31:0] cfg_data = 32'd0;

  rssi_scalar_kalman_filter u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .rssi_dbm       (rssi_dbm),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .smoothed_rssi  (smoothed_rssi),
    .error_variance (error_variance),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // filter copy kept by the testbench
  logic               kf_seeded = 1'b0;
  logic signed [15:0] kf_est = '0;
  logic [31:0]        kf_var = '0;
  logic [31:0]        set_q = RST_Q;
  logic [31:0]        set_r = RST_R;
  logic [31:0]        set_init = RST_INIT;

  kf_result_t  outstanding[$];
  int unsigned cycles = 0;
  int unsigned samples_sent = 0;
  int unsigned results_seen = 0;
  int unsigned reg_writes = 0;
  int unsigned mismatches = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_idle_pct = 0;
  bit          hold_req = 1'b0;

  plan_row_t directed_plan [24] = '{
    '{ROW_ITEM, REG_Q,    32'd0,        8'h80, 1'b0, 16'h0000, 32'd0},
    '{ROW_ITEM, REG_Q,    32'd0,        8'h7F, 1'b0, 16'h0000, 32'd0},
    '{ROW_ITEM, REG_Q,    32'd0,        8'h00, 1'b0, 16'h0000, 32'd0},
    '{ROW_CFG,  REG_R,    32'd0,        8'h00, 1'b0, 16'h0000, 32'd0},
    '{ROW_ITEM, REG_Q,    32'd0,        8'h7F, 1'b1, 16'h7F00, 32'd0},
    '{ROW_ITEM, REG_Q,    32'd0,        8'h80, 1'b1, 16'h8000, 32'd0},
    '{ROW_CFG,  REG_Q,    32'd0,        8'h00, 1'b0, 16'h0000, 32'd0},
    '{ROW_ITEM, REG_Q,    32'd0,        8'h05, 1'b1, 16'h8000, 32'd0},
    '{ROW_CFG,  REG_Q,    32'hFFFFFFFF, 8'h00, 1'b0, 16'h0000, 32'd0},
    '{ROW_CFG,  REG_R,    32'hFFFFFFFF, 8'h00, 1'b0, 16'h0000, 32'd0},
    '{ROW_ITEM, REG_Q,    32'd0,        8'h7F, 1'b0, 16'h0000, 32'd0},
    '{ROW_ITEM, REG_Q,    32'd0,        8'hFF, 1'b0, 16'h0000, 32'd0},
    '{ROW_CFG,  REG_INIT, 32'hFFFFFFFF, 8'h00, 1'b0, 16'h0000, 32'd0},
    '{ROW_ITEM, REG_Q,    32'd0,        8'h40, 1'b0, 16'h0000, 32'd0},
    '{ROW_CFG,  REG_NONE, 32'd0,        8'h00, 1'b0, 16'h0000, 32'd0},
    '{ROW_ITEM, REG_Q,    32'd0,        8'hC0, 1'b0, 16'h0000, 32'd0},
    '{ROW_CFG,  REG_Q,    32'd1,        8'h00, 1'b0, 16'h0000, 32'd0},
    '{ROW_ITEM, REG_Q,    32'd0,        8'h01, 1'b0, 16'h0000, 32'd0},
    '{ROW_ITEM, REG_Q,    32'd0,        8'hFE, 1'b0, 16'h0000, 32'd0},
    '{ROW_CFG,  REG_Q,    RST_Q,        8'h00, 1'b0, 16'h0000, 32'd0},
    '{ROW_CFG,  REG_R,    RST_R,        8'h00, 1'b0, 16'h0000, 32'd0},
    '{ROW_CFG,  REG_INIT, RST_INIT,     8'h00, 1'b0, 16'h0000, 32'd0},
    '{ROW_ITEM, REG_Q,    32'd0,        8'h55, 1'b0, 16'h0000, 32'd0},
    '{ROW_ITEM, REG_Q,    32'd0,        8'hAA, 1'b0, 16'h0000, 32'd0}
  };

  function automatic kf_result_t kalman_update(logic [7:0] sample);
    logic [32:0]        prior;
    logic [33:0]        den;
    logic [63:0]        gain;
    logic signed [63:0] innov;
    logic signed [63:0] delta;
    logic [63:0]        post;
    kf_result_t         res;
    if (!kf_seeded) begin
      kf_est = {sample, 8'd0};
      kf_var = set_init;
      kf_seeded = 1'b1;
    end
    prior = {1'b0, kf_var} + {1'b0, set_q};
    if (prior[32]) begin
      prior = 33'h0_FFFF_FFFF;
    end
    den = {1'b0, prior} + {2'b00, set_r};
    gain = (den == '0) ? 64'd0 : ({31'd0, prior} << 16) / {30'd0, den};
    if (gain > 64'd65536) begin
      gain = 64'd65536;
    end
    innov = {{48{sample[7]}}, sample, 8'd0} - {{48{kf_est[15]}}, kf_est};
    // arithmetic shift gives the floor for negative products
    delta = ($signed(gain) * innov) >>> 16;
    kf_est = kf_est + delta[15:0];
    post = (64'd65536 - gain) * {31'd0, prior};
    kf_var = post[47:16];
    res.est_q88 = kf_est;
    res.var_q16 = kf_var;
    return res;
  endfunction

  function automatic logic [31:0] pick_setting();
    case ($urandom_range(7))
      0: return 32'd0;
      1: return 32'hFFFFFFFF;
      2: return $urandom;
      3: return $urandom_range(32'h0010_0000);
      4: return $urandom_range(1023);
      default: return $urandom_range(32'h0004_0000);
    endcase
  endfunction

  task automatic send_sample(logic [7:0] v);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 40)) @(posedge clk);
    end
    in_valid <= 1'b1;
    rssi_dbm <= v;
    do @(posedge clk); while (!in_ready);
    outstanding.push_back(kalman_update(v));
    samples_sent++;
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_Q:    set_q = data;
      REG_R:    set_r = data;
      REG_INIT: set_init = data;
      default: ;
    endcase
    reg_writes++;
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    while (outstanding.size() != 0 || !in_ready) @(posedge clk);
  endtask

  // stimulus
  initial begin
    bit         cfg_open;
    logic [7:0] v;
    logic [7:0] prev;
    cfg_open = 1'b0;
    prev = 8'd0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_plan[i]) begin
      if (directed_plan[i].kind == ROW_CFG) begin
        wait_idle();
        write_reg(directed_plan[i].idx, directed_plan[i].data);
        cfg_open = 1'b1;
      end else begin
        if (cfg_open) begin
          cfg_valid <= 1'b0;
          cfg_open = 1'b0;
        end
        send_sample(directed_plan[i].rssi);
        if (directed_plan[i].typed) begin
          outstanding[outstanding.size() - 1] =
            '{directed_plan[i].t_est, directed_plan[i].t_var};
        end
      end
    end

    for (int mode = 0; mode < 3; mode++) begin
      for (int seg = 0; seg < SEGMENTS; seg++) begin
        wait_idle();
        tx_idle_pct = (mode == 0) ? 30 : (mode == 1) ? 55 : 0;
        rx_idle_pct = (mode == 0) ? 55 : (mode == 1) ? 30 : 0;
        if (mode == 2 && seg == 0) begin
          hold_req = 1'b1;
        end
        repeat ($urandom_range(1, 3)) write_reg(2'($urandom_range(3)), pick_setting());
        cfg_valid <= 1'b0;
        for (int n = 0; n < SEG_ITEMS; n++) begin
          case ($urandom_range(9))
            0:       v = $urandom_range(1) ? 8'h7F : 8'h80;
            1, 2:    v = prev + 8'($urandom_range(6)) - 8'd3;
            default: v = 8'($urandom_range(255));
          endcase
          prev = v;
          send_sample(v);
        end
      end
    end

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("covered %0d samples and %0d register writes, %0d results checked,",
             samples_sent, reg_writes, results_seen);
    $display("three stall mixes and one long output hold; %0d mismatches", mismatches);
    if (mismatches == 0 && outstanding.size() == 0) begin
      $display("** rssi_scalar_kalman_filter: PASSED **");
    end else begin
      $display("** rssi_scalar_kalman_filter: FAILED **");
    end
    $finish;
  end

  // result side: check, then choose the next ready
  initial begin
    int unsigned hold_left;
    bit          hold_done;
    kf_result_t  want;
    hold_left = 0;
    hold_done = 1'b0;
    forever begin
      @(posedge clk);
      if (!rst && out_valid && out_ready) begin
        results_seen++;
        if (outstanding.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("unexpected result: est %h var %h", smoothed_rssi, error_variance);
          end
        end else begin
          want = outstanding.pop_front();
          if (smoothed_rssi !== want.est_q88 || error_variance !== want.var_q16) begin
            mismatches++;
            if (mismatches <= 10) begin
              $display("mismatch on result %0d: expected est %h var %h, got est %h var %h",
                       results_seen, want.est_q88, want.var_q16,
                       smoothed_rssi, error_variance);
            end
          end
        end
      end
      if (hold_left != 0) begin
        out_ready <= 1'b0;
        hold_left--;
      end else if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        hold_left = LONG_HOLD - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycles);
      $display("** rssi_scalar_kalman_filter: FAILED **");
      $finish;
    end
  end

endmodule
`default_nettype wire

@@ sim.f @@
+incdir+src
src/rskf_pkg.sv
src/rskf_ctrl.sv
src/rskf_datapath.sv
src/rssi_scalar_kalman_filter.sv
dv/tb_top.sv
